>>> sv/tun_pkg.sv
// ----------------------------------------------------------------------------
// tun_pkg
// Shared widths, types and helpers for the triangle unit normal pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package tun_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 14;
  localparam int N_COORD    = 9;
  localparam int OUT_W      = 16;

  localparam int DW   = COORD_BITS + 1;         // edge component
  localparam int PW   = 2 * DW;                 // edge product
  localparam int NW   = PW + 1;                 // cross product component
  localparam int MW   = NW - 1;                 // magnitude of a component
  localparam int HS   = (MW + 1) / 2;           // split point for squaring
  localparam int HW   = MW - HS;
  localparam int PPW  = 2 * HS;                 // partial product
  localparam int SQW  = 2 * MW;                 // square of a component
  localparam int LW   = SQW + 2;                // squared length
  localparam int WW   = LW + 2 * FRAC_BITS + 5; // root datapath
  localparam int QW   = FRAC_BITS + 2;          // root result bits
  localparam int RSH  = 2 * FRAC_BITS + 2;

  localparam int IN_TDATA_W  = ((N_COORD * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((3 * OUT_W + 7) / 8) * 8;

  localparam int CROSS_ST = 3;
  localparam int SQR_ST   = 3;
  localparam int ROOT_ST  = QW;
  localparam int NS       = CROSS_ST + SQR_ST + ROOT_ST + 1;

  typedef struct packed {
    logic [WW-1:0] rem;
    logic [WW-1:0] p;
    logic [QW-1:0] q;
  } lane_t;

  typedef struct packed {
    lane_t [2:0]   lane;
    logic [WW-1:0] b;
    logic [2:0]    neg;
    logic          zero;
  } root_t;

  function automatic logic signed [DW-1:0] sext(input logic [COORD_BITS-1:0] v);
    return signed'({v[COORD_BITS-1], v});
  endfunction

  function automatic logic [OUT_W-1:0] fit_out(input logic [QW:0] v);
    logic [OUT_W-1:0] r;
    for (int i = 0; i < OUT_W; i++) begin
      r[i] = (i <= QW) ? v[i] : v[QW];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> sv/triangle_unit_normal.sv
// ----------------------------------------------------------------------------
// triangle_unit_normal
// Unit face normal of a triangle in signed Q1.14, exact round to nearest.
// ----------------------------------------------------------------------------
// Takes one triangle request per cycle while the output side does not stall,
// and returns one result per request, in order. There are 23 register stages:
// the 16 root stages, one result bit each, are preceded by six stages for the
// cross product and squared length, and one output stage follows. A
// degenerate triangle gives a zero normal with tuser high. Empty stages close
// up under back-pressure, so input is taken while a finished result still
// waits.
`default_nettype none

module triangle_unit_normal (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
  input  wire logic [tun_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  output logic                                 m_axis_tvalid_o,
  input  wire logic                            m_axis_tready_i,
  // norm_x, norm_y, norm_z
  output logic [tun_pkg::OUT_TDATA_W-1:0]      m_axis_tdata_o,
  // degenerate
  output logic                                 m_axis_tuser_o
);
  import tun_pkg::*;

  logic [NS-1:0]                     v_q;
  logic [NS-1:0]                     en;
  logic [N_COORD-1:0][COORD_BITS-1:0] coord;
  logic [2:0][MW-1:0]                mag;
  logic [2:0]                        neg;
  logic                              zero;
  root_t                             rs [ROOT_ST+1];
  logic [2:0][QW-1:0]                r_w;
  logic [2:0][OUT_W-1:0]             norm_d;
  logic [2:0][OUT_W-1:0]             norm_q;
  logic                              deg_q;

  always_comb begin
    en[NS-1] = !v_q[NS-1] || m_axis_tready_i;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = !v_q[i] || en[i+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= s_axis_tvalid_i;
      for (int i = 1; i < NS; i++) begin
        if (en[i]) v_q[i] <= v_q[i-1];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < N_COORD; i++) begin
      coord[i] = s_axis_tdata_i[i*COORD_BITS +: COORD_BITS];
    end
  end

  tun_cross u_cross (
    .clk_i   (clk_i),
    .en_i    (en[CROSS_ST-1:0]),
    .coord_i (coord),
    .mag_o   (mag),
    .neg_o   (neg),
    .zero_o  (zero)
  );

  tun_sqr u_sqr (
    .clk_i  (clk_i),
    .en_i   (en[CROSS_ST +: SQR_ST]),
    .mag_i  (mag),
    .neg_i  (neg),
    .zero_i (zero),
    .root_o (rs[0])
  );

  for (genvar k = 0; k < ROOT_ST; k++) begin : g_root
    tun_root u_root (
      .clk_i  (clk_i),
      .en_i   (en[CROSS_ST + SQR_ST + k]),
      .root_i (rs[k]),
      .root_o (rs[k+1])
    );
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      r_w[i] = QW'((({1'b0, rs[ROOT_ST].lane[i].q}) + (QW+1)'(1)) >> 1);
      if (rs[ROOT_ST].zero) begin
        norm_d[i] = '0;
      end else if (rs[ROOT_ST].neg[i]) begin
        norm_d[i] = fit_out(-{1'b0, r_w[i]});
      end else begin
        norm_d[i] = fit_out({1'b0, r_w[i]});
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[NS-1]) begin
      norm_q <= norm_d;
      deg_q  <= rs[ROOT_ST].zero;
    end
  end

  assign s_axis_tready_o = en[0];
  assign m_axis_tvalid_o = v_q[NS-1];
  assign m_axis_tdata_o  = OUT_TDATA_W'({norm_q[2], norm_q[1], norm_q[0]});
  assign m_axis_tuser_o  = deg_q;

  a_deg_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o == '0)
    else $error("degenerate result with non-zero normal");

  a_unit_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[NS-2] && !rs[ROOT_ST].zero |->
      r_w[0] <= QW'(1 << FRAC_BITS) && r_w[1] <= QW'(1 << FRAC_BITS)
      && r_w[2] <= QW'(1 << FRAC_BITS))
    else $error("normal component above one");

  a_ready_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> v_q[0] && m_axis_tvalid_o && !m_axis_tready_i)
    else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire

>>> sv/tun_cross.sv
// ----------------------------------------------------------------------------
// tun_cross
// Edge vectors, their cross product and per-component magnitude and sign.
// ----------------------------------------------------------------------------
`default_nettype none

module tun_cross (
  input  wire logic                                  clk_i,
  input  wire logic [tun_pkg::CROSS_ST-1:0]          en_i,
  input  wire logic [tun_pkg::N_COORD-1:0][tun_pkg::COORD_BITS-1:0] coord_i,
  output logic      [2:0][tun_pkg::MW-1:0]           mag_o,
  output logic      [2:0]                            neg_o,
  output logic                                       zero_o
);
  import tun_pkg::*;

  logic signed [DW-1:0] e_d [3];
  logic signed [DW-1:0] g_d [3];
  logic signed [DW-1:0] e_q [3];
  logic signed [DW-1:0] g_q [3];
  logic signed [PW-1:0] p_d [6];
  logic signed [PW-1:0] p_q [6];
  logic signed [NW-1:0] n_d [3];
  logic [2:0][MW-1:0]   mag_q;
  logic [2:0]           neg_q;
  logic                 zero_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e_d[i] = sext(coord_i[3 + i]) - sext(coord_i[i]);
      g_d[i] = sext(coord_i[6 + i]) - sext(coord_i[i]);
    end
  end

  always_comb begin
    p_d[0] = PW'(e_q[1]) * PW'(g_q[2]);
    p_d[1] = PW'(e_q[2]) * PW'(g_q[1]);
    p_d[2] = PW'(e_q[2]) * PW'(g_q[0]);
    p_d[3] = PW'(e_q[0]) * PW'(g_q[2]);
    p_d[4] = PW'(e_q[0]) * PW'(g_q[1]);
    p_d[5] = PW'(e_q[1]) * PW'(g_q[0]);
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n_d[i] = NW'(p_q[2*i]) - NW'(p_q[2*i+1]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      for (int i = 0; i < 3; i++) begin
        e_q[i] <= e_d[i];
        g_q[i] <= g_d[i];
      end
    end
    if (en_i[1]) begin
      for (int i = 0; i < 6; i++) begin
        p_q[i] <= p_d[i];
      end
    end
    if (en_i[2]) begin
      for (int i = 0; i < 3; i++) begin
        neg_q[i] <= n_d[i][NW-1];
        mag_q[i] <= n_d[i][NW-1] ? MW'(-n_d[i]) : MW'(n_d[i]);
      end
      zero_q <= (n_d[0] == '0) && (n_d[1] == '0) && (n_d[2] == '0);
    end
  end

  assign mag_o  = mag_q;
  assign neg_o  = neg_q;
  assign zero_o = zero_q;

endmodule

`default_nettype wire

>>> sv/tun_sqr.sv
// ----------------------------------------------------------------------------
// tun_sqr
// Squares of the components in split partial products, squared length, and
// the starting values of the root stages.
// ----------------------------------------------------------------------------
`default_nettype none

module tun_sqr (
  input  wire logic                          clk_i,
  input  wire logic [tun_pkg::SQR_ST-1:0]    en_i,
  input  wire logic [2:0][tun_pkg::MW-1:0]   mag_i,
  input  wire logic [2:0]                    neg_i,
  input  wire logic                          zero_i,
  output tun_pkg::root_t                     root_o
);
  import tun_pkg::*;

  logic [PPW-1:0] hh_q [3];
  logic [PPW-1:0] hl_q [3];
  logic [PPW-1:0] ll_q [3];
  logic [SQW-1:0] sq_q [3];
  logic [2:0]     neg4_q, neg5_q;
  logic           zero4_q, zero5_q;
  logic [LW-1:0]  len_d;
  root_t          root_d, root_q;

  always_comb begin
    len_d = LW'(sq_q[0]) + LW'(sq_q[1]) + LW'(sq_q[2]);
    root_d.b    = WW'(len_d) << RSH;
    root_d.neg  = neg5_q;
    root_d.zero = zero5_q;
    for (int i = 0; i < 3; i++) begin
      root_d.lane[i].rem = WW'(sq_q[i]) << RSH;
      root_d.lane[i].p   = '0;
      root_d.lane[i].q   = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      for (int i = 0; i < 3; i++) begin
        hh_q[i] <= PPW'(mag_i[i][MW-1:HS]) * PPW'(mag_i[i][MW-1:HS]);
        hl_q[i] <= PPW'(mag_i[i][MW-1:HS]) * PPW'(mag_i[i][HS-1:0]);
        ll_q[i] <= PPW'(mag_i[i][HS-1:0]) * PPW'(mag_i[i][HS-1:0]);
      end
      neg4_q  <= neg_i;
      zero4_q <= zero_i;
    end
    if (en_i[1]) begin
      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= (SQW'(hh_q[i]) << (2 * HS)) + (SQW'(hl_q[i]) << (HS + 1))
                   + SQW'(ll_q[i]);
      end
      neg5_q  <= neg4_q;
      zero5_q <= zero4_q;
    end
    if (en_i[2]) begin
      root_q <= root_d;
    end
  end

  assign root_o = root_q;

endmodule

`default_nettype wire

>>> sv/tun_root.sv
// ----------------------------------------------------------------------------
// tun_root
// One shift-and-subtract step of the scaled root, one result bit per lane.
// ----------------------------------------------------------------------------
`default_nettype none

module tun_root (
  input  wire logic           clk_i,
  input  wire logic           en_i,
  input  wire tun_pkg::root_t root_i,
  output tun_pkg::root_t      root_o
);
  import tun_pkg::*;

  logic [WW-1:0] dsum [3];
  logic [2:0]    take;
  root_t         root_d, root_q;

  always_comb begin
    root_d.b    = root_i.b >> 2;
    root_d.neg  = root_i.neg;
    root_d.zero = root_i.zero;
    for (int i = 0; i < 3; i++) begin
      dsum[i] = root_i.lane[i].p + root_i.b;
      take[i] = dsum[i] <= root_i.lane[i].rem;
      root_d.lane[i].rem = take[i] ? root_i.lane[i].rem - dsum[i] : root_i.lane[i].rem;
      root_d.lane[i].p   = (root_i.lane[i].p >> 1) + (take[i] ? root_i.b : '0);
      root_d.lane[i].q   = {root_i.lane[i].q[QW-2:0], take[i]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      root_q <= root_d;
    end
  end

  assign root_o = root_q;

endmodule

`default_nettype wire
